// ----- sv/via_pkg.sv -----
// types, codes and constants shared by the interface adapter files
package via_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    REG_ORB   = 4'd0,
    REG_ORA   = 4'd1,
    REG_DDRB  = 4'd2,
    REG_DDRA  = 4'd3,
    REG_T1CL  = 4'd4,
    REG_T1CH  = 4'd5,
    REG_T1LL  = 4'd6,
    REG_T1LH  = 4'd7,
    REG_T2CL  = 4'd8,
    REG_T2CH  = 4'd9,
    REG_SR    = 4'd10,
    REG_ACR   = 4'd11,
    REG_PCR   = 4'd12,
    REG_IFR   = 4'd13,
    REG_IER   = 4'd14,
    REG_ORA_NH = 4'd15
  } reg_e;

  localparam int unsigned FlagW = 7;

  localparam logic [FlagW-1:0] FLAG_CA2 = 7'h01;
  localparam logic [FlagW-1:0] FLAG_CA1 = 7'h02;
  localparam logic [FlagW-1:0] FLAG_SR  = 7'h04;
  localparam logic [FlagW-1:0] FLAG_CB2 = 7'h08;
  localparam logic [FlagW-1:0] FLAG_CB1 = 7'h10;
  localparam logic [FlagW-1:0] FLAG_T2  = 7'h20;
  localparam logic [FlagW-1:0] FLAG_T1  = 7'h40;

  localparam logic [2:0] CTRL_MANUAL_LOW  = 3'd6;
  localparam logic [2:0] CTRL_MANUAL_HIGH = 3'd7;

  localparam int unsigned ACR_T1_FREE_RUN = 6;
  localparam int unsigned ACR_T1_PB7      = 7;

  localparam logic [15:0] TIMER_RESET = 16'hFFFF;
  localparam logic [7:0]  LATCH_LOW_RESET = 8'hFF;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic       ca1_event;
    logic       ca2_event;
    logic       cb1_event;
    logic       cb2_event;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_a_dir;
    logic [7:0] port_b_out;
    logic [7:0] port_b_dir;
    logic       ca2_level;
    logic       cb2_level;
  } out_t;

  function automatic logic [7:0] port_value(logic [7:0] outr, logic [7:0] dir,
                                            logic [7:0] pins);
    return (outr & dir) | (pins & ~dir);
  endfunction

endpackage

// ----- sv/via_if.sv -----
// valid/ready channels carrying request and result words
interface via_in_if;
  import via_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface via_out_if;
  import via_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/versatile_interface_adapter_top.sv -----
// 6522-style interface adapter: bus registers, two timers, interrupt flags
// One request word (bus read, bus write, timer tick or no action) is taken per
// clock and gives one result word in the output register in the next cycle. The
// next request is taken while that result waits, as long as the sink takes it in
// the same cycle, so the sustained rate is one word per clock. All register,
// timer and flag updates are taken into their registers at acceptance, with the
// output register; reads return the register value as it stood before any
// flag clear that the read causes, and the other result fields show the state
// after the update.
module versatile_interface_adapter_top
  import via_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  via_in_if.sink      in_i,
  via_out_if.source   out_o
);

  logic [7:0]       ora_q, ora_d, orb_q, orb_d, ddra_q, ddra_d, ddrb_q, ddrb_d;
  logic [15:0]      t1_count_q, t1_count_d, t1_latch_q, t1_latch_d;
  logic [15:0]      t2_count_q, t2_count_d;
  logic [7:0]       t2_latch_low_q, t2_latch_low_d;
  logic [7:0]       sr_q, sr_d, acr_q, acr_d, pcr_q, pcr_d;
  logic [FlagW-1:0] flags_q, flags_d, en_q, en_d;
  logic             t1_active_q, t1_active_d, t2_active_q, t2_active_d;
  logic             ca2_q, ca2_d, cb2_q, cb2_d;
  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             in_acc;
  logic [7:0]       rd;
  logic [15:0]      t1_dec, t2_dec;
  in_t              req;

  assign req       = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc    = in_i.valid && in_i.ready;
  assign t1_dec    = t1_count_q - 16'd1;
  assign t2_dec    = t2_count_q - 16'd1;

  always_comb begin
    ora_d = ora_q; orb_d = orb_q; ddra_d = ddra_q; ddrb_d = ddrb_q;
    t1_count_d = t1_count_q; t1_latch_d = t1_latch_q; t2_count_d = t2_count_q;
    t2_latch_low_d = t2_latch_low_q;
    sr_d = sr_q; acr_d = acr_q; pcr_d = pcr_q;
    flags_d = flags_q; en_d = en_q;
    t1_active_d = t1_active_q; t2_active_d = t2_active_q;
    ca2_d = ca2_q; cb2_d = cb2_q;
    rd = 8'h00;

    case (action_e'(req.action))
      ACT_READ: begin
        unique case (reg_e'(req.reg_addr))
          REG_ORB: begin
            flags_d = flags_q & ~(FLAG_CB1 | FLAG_CB2);
            rd = port_value(orb_q, ddrb_q, req.port_b_pins);
          end
          REG_ORA: begin
            flags_d = flags_q & ~(FLAG_CA1 | FLAG_CA2);
            rd = port_value(ora_q, ddra_q, req.port_a_pins);
          end
          REG_DDRB: rd = ddrb_q;
          REG_DDRA: rd = ddra_q;
          REG_T1CL: begin
            flags_d = flags_q & ~FLAG_T1;
            rd = t1_count_q[7:0];
          end
          REG_T1CH: rd = t1_count_q[15:8];
          REG_T1LL: rd = t1_latch_q[7:0];
          REG_T1LH: rd = t1_latch_q[15:8];
          REG_T2CL: begin
            flags_d = flags_q & ~FLAG_T2;
            rd = t2_count_q[7:0];
          end
          REG_T2CH: rd = t2_count_q[15:8];
          REG_SR: begin
            flags_d = flags_q & ~FLAG_SR;
            rd = sr_q;
          end
          REG_ACR: rd = acr_q;
          REG_PCR: rd = pcr_q;
          REG_IFR: rd = {|(flags_q & en_q), flags_q};
          REG_IER: rd = {1'b1, en_q};
          default: rd = port_value(ora_q, ddra_q, req.port_a_pins);
        endcase
      end
      ACT_WRITE: begin
        unique case (reg_e'(req.reg_addr))
          REG_ORB: begin
            flags_d = flags_q & ~(FLAG_CB1 | FLAG_CB2);
            orb_d = req.write_data;
          end
          REG_ORA: begin
            flags_d = flags_q & ~(FLAG_CA1 | FLAG_CA2);
            ora_d = req.write_data;
          end
          REG_DDRB: ddrb_d = req.write_data;
          REG_DDRA: ddra_d = req.write_data;
          REG_T1CL, REG_T1LL: t1_latch_d = {t1_latch_q[15:8], req.write_data};
          REG_T1CH: begin
            t1_latch_d  = {req.write_data, t1_latch_q[7:0]};
            t1_count_d  = {req.write_data, t1_latch_q[7:0]};
            flags_d     = flags_q & ~FLAG_T1;
            t1_active_d = 1'b1;
          end
          REG_T1LH: begin
            t1_latch_d = {req.write_data, t1_latch_q[7:0]};
            flags_d    = flags_q & ~FLAG_T1;
          end
          REG_T2CL: t2_latch_low_d = req.write_data;
          REG_T2CH: begin
            t2_count_d  = {req.write_data, t2_latch_low_q};
            flags_d     = flags_q & ~FLAG_T2;
            t2_active_d = 1'b1;
          end
          REG_SR: begin
            sr_d    = req.write_data;
            flags_d = flags_q & ~FLAG_SR;
          end
          REG_ACR: acr_d = req.write_data;
          REG_PCR: begin
            pcr_d = req.write_data;
            if (req.write_data[3:1] == CTRL_MANUAL_LOW) ca2_d = 1'b0;
            else if (req.write_data[3:1] == CTRL_MANUAL_HIGH) ca2_d = 1'b1;
            if (req.write_data[7:5] == CTRL_MANUAL_LOW) cb2_d = 1'b0;
            else if (req.write_data[7:5] == CTRL_MANUAL_HIGH) cb2_d = 1'b1;
          end
          REG_IFR: flags_d = flags_q & ~req.write_data[FlagW-1:0];
          REG_IER: begin
            if (req.write_data[7]) en_d = en_q | req.write_data[FlagW-1:0];
            else en_d = en_q & ~req.write_data[FlagW-1:0];
          end
          default: ora_d = req.write_data;
        endcase
      end
      ACT_TICK: begin
        // timers first, then the line events
        if (t1_active_q && t1_count_q != 16'd0) begin
          t1_count_d = t1_dec;
          if (t1_dec == 16'd0) begin
            flags_d = flags_d | FLAG_T1;
            if (acr_q[ACR_T1_FREE_RUN]) t1_count_d = t1_latch_q;
            else t1_active_d = 1'b0;
            if (acr_q[ACR_T1_PB7]) orb_d = orb_q ^ 8'h80;
          end
        end
        if (t2_active_q && t2_count_q != 16'd0) begin
          t2_count_d = t2_dec;
          if (t2_dec == 16'd0) begin
            flags_d     = flags_d | FLAG_T2;
            t2_active_d = 1'b0;
          end
        end
        if (req.ca1_event) flags_d = flags_d | FLAG_CA1;
        if (req.ca2_event) flags_d = flags_d | FLAG_CA2;
        if (req.cb1_event) flags_d = flags_d | FLAG_CB1;
        if (req.cb2_event) flags_d = flags_d | FLAG_CB2;
      end
      default: rd = 8'h00;
    endcase

    out_d.read_data  = rd;
    out_d.irq        = |(flags_d & en_d);
    out_d.port_a_out = ora_d;
    out_d.port_a_dir = ddra_d;
    out_d.port_b_out = orb_d;
    out_d.port_b_dir = ddrb_d;
    out_d.ca2_level  = ca2_d;
    out_d.cb2_level  = cb2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ora_q <= '0; orb_q <= '0; ddra_q <= '0; ddrb_q <= '0;
      t1_count_q <= TIMER_RESET; t1_latch_q <= TIMER_RESET;
      t2_count_q <= TIMER_RESET; t2_latch_low_q <= LATCH_LOW_RESET;
      sr_q <= '0; acr_q <= '0; pcr_q <= '0;
      flags_q <= '0; en_q <= '0;
      t1_active_q <= 1'b0; t2_active_q <= 1'b0;
      ca2_q <= 1'b0; cb2_q <= 1'b0;
    end else if (in_acc) begin
      ora_q <= ora_d; orb_q <= orb_d; ddra_q <= ddra_d; ddrb_q <= ddrb_d;
      t1_count_q <= t1_count_d; t1_latch_q <= t1_latch_d;
      t2_count_q <= t2_count_d; t2_latch_low_q <= t2_latch_low_d;
      sr_q <= sr_d; acr_q <= acr_d; pcr_q <= pcr_d;
      flags_q <= flags_d; en_q <= en_d;
      t1_active_q <= t1_active_d; t2_active_q <= t2_active_d;
      ca2_q <= ca2_d; cb2_q <= cb2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // a result word always follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> out_valid_q)
    else $error("result word missing after accepted request");

  // pending result reflects the live interrupt state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.irq == |(flags_q & en_q)))
    else $error("irq in result disagrees with flag and enable registers");

  // pending result mirrors the port output registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.port_b_out == orb_q && out_q.port_a_out == ora_q))
    else $error("port output in result disagrees with port registers");

  // a stopped timer one only restarts through a high counter write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!t1_active_q && in_acc &&
     !(req.action == ACT_WRITE && req.reg_addr == REG_T1CH)) |=> !t1_active_q)
    else $error("timer one started without a counter write");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the 6522-style interface adapter: directed and random bus traffic
module testbench;
  import via_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_ni;

  via_in_if  req_if ();
  via_out_if rsp_if ();

  versatile_interface_adapter_top dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  always #5 clk = ~clk;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles   = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  out_t pending_results[$];

  logic [7:0]       pa_out, pa_dir, pb_out, pb_dir;
  logic [7:0]       sr_byte, acr_byte, pcr_byte, t2_latch_lo;
  logic [15:0]      t1_count, t1_latch, t2_count;
  logic [FlagW-1:0] ifr_bits, ier_bits;
  logic             t1_armed, t2_armed, ca2_out, cb2_out;

  function automatic void reset_adapter_model();
    pa_out      = '0;
    pa_dir      = '0;
    pb_out      = '0;
    pb_dir      = '0;
    sr_byte     = '0;
    acr_byte    = '0;
    pcr_byte    = '0;
    t1_count    = TIMER_RESET;
    t1_latch    = TIMER_RESET;
    t2_count    = TIMER_RESET;
    t2_latch_lo = LATCH_LOW_RESET;
    ifr_bits    = '0;
    ier_bits    = '0;
    t1_armed    = 1'b0;
    t2_armed    = 1'b0;
    ca2_out     = 1'b0;
    cb2_out     = 1'b0;
  endfunction

  function automatic logic [7:0] port_level(logic [7:0] latch, logic [7:0] dir,
                                            logic [7:0] pins);
    return (latch & dir) | (pins & ~dir);
  endfunction

  function automatic out_t predict_adapter_word(in_t req);
    out_t       res;
    logic [7:0] rd;
    logic [7:0] d;
    rd = '0;
    d  = req.write_data;
    case (action_e'(req.action))
      ACT_READ: begin
        case (reg_e'(req.reg_addr))
          REG_ORB: begin
            rd = port_level(pb_out, pb_dir, req.port_b_pins);
            ifr_bits &= ~(FLAG_CB1 | FLAG_CB2);
          end
          REG_ORA: begin
            rd = port_level(pa_out, pa_dir, req.port_a_pins);
            ifr_bits &= ~(FLAG_CA1 | FLAG_CA2);
          end
          REG_DDRB: rd = pb_dir;
          REG_DDRA: rd = pa_dir;
          REG_T1CL: begin
            rd = t1_count[7:0];
            ifr_bits &= ~FLAG_T1;
          end
          REG_T1CH: rd = t1_count[15:8];
          REG_T1LL: rd = t1_latch[7:0];
          REG_T1LH: rd = t1_latch[15:8];
          REG_T2CL: begin
            rd = t2_count[7:0];
            ifr_bits &= ~FLAG_T2;
          end
          REG_T2CH: rd = t2_count[15:8];
          REG_SR: begin
            rd = sr_byte;
            ifr_bits &= ~FLAG_SR;
          end
          REG_ACR: rd = acr_byte;
          REG_PCR: rd = pcr_byte;
          REG_IFR: rd = {|(ifr_bits & ier_bits), ifr_bits};
          REG_IER: rd = {1'b1, ier_bits};
          REG_ORA_NH: rd = port_level(pa_out, pa_dir, req.port_a_pins);
        endcase
      end
      ACT_WRITE: begin
        case (reg_e'(req.reg_addr))
          REG_ORB: begin
            ifr_bits &= ~(FLAG_CB1 | FLAG_CB2);
            pb_out = d;
          end
          REG_ORA: begin
            ifr_bits &= ~(FLAG_CA1 | FLAG_CA2);
            pa_out = d;
          end
          REG_DDRB: pb_dir = d;
          REG_DDRA: pa_dir = d;
          REG_T1CL, REG_T1LL: t1_latch[7:0] = d;
          REG_T1CH: begin
            t1_latch[15:8] = d;
            t1_count = t1_latch;
            ifr_bits &= ~FLAG_T1;
            t1_armed = 1'b1;
          end
          REG_T1LH: begin
            t1_latch[15:8] = d;
            ifr_bits &= ~FLAG_T1;
          end
          REG_T2CL: t2_latch_lo = d;
          REG_T2CH: begin
            t2_count = {d, t2_latch_lo};
            ifr_bits &= ~FLAG_T2;
            t2_armed = 1'b1;
          end
          REG_SR: begin
            sr_byte = d;
            ifr_bits &= ~FLAG_SR;
          end
          REG_ACR: acr_byte = d;
          REG_PCR: begin
            pcr_byte = d;
            if (d[3:1] == CTRL_MANUAL_LOW) ca2_out = 1'b0;
            else if (d[3:1] == CTRL_MANUAL_HIGH) ca2_out = 1'b1;
            if (d[7:5] == CTRL_MANUAL_LOW) cb2_out = 1'b0;
            else if (d[7:5] == CTRL_MANUAL_HIGH) cb2_out = 1'b1;
          end
          REG_IFR: ifr_bits &= ~d[6:0];
          REG_IER: begin
            if (d[7]) ier_bits |= d[6:0];
            else ier_bits &= ~d[6:0];
          end
          REG_ORA_NH: pa_out = d;
        endcase
      end
      ACT_TICK: begin
        // timers first, then the event flags
        if (t1_armed && t1_count != 16'd0) begin
          t1_count = t1_count - 16'd1;
          if (t1_count == 16'd0) begin
            ifr_bits |= FLAG_T1;
            if (acr_byte[ACR_T1_FREE_RUN]) t1_count = t1_latch;
            else t1_armed = 1'b0;
            if (acr_byte[ACR_T1_PB7]) pb_out[7] = ~pb_out[7];
          end
        end
        if (t2_armed && t2_count != 16'd0) begin
          t2_count = t2_count - 16'd1;
          if (t2_count == 16'd0) begin
            ifr_bits |= FLAG_T2;
            t2_armed = 1'b0;
          end
        end
        if (req.ca1_event) ifr_bits |= FLAG_CA1;
        if (req.ca2_event) ifr_bits |= FLAG_CA2;
        if (req.cb1_event) ifr_bits |= FLAG_CB1;
        if (req.cb2_event) ifr_bits |= FLAG_CB2;
      end
      default: begin
      end
    endcase
    res.read_data  = rd;
    res.irq        = |(ifr_bits & ier_bits);
    res.port_a_out = pa_out;
    res.port_a_dir = pa_dir;
    res.port_b_out = pb_out;
    res.port_b_dir = pb_dir;
    res.ca2_level  = ca2_out;
    res.cb2_level  = cb2_out;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic send_word(input in_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= req;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(predict_adapter_word(req));
  endtask

  function automatic in_t make_word(action_e act, reg_e addr, logic [7:0] d,
                                    logic [7:0] pa, logic [7:0] pb, logic [3:0] ev);
    in_t req;
    req.action      = act;
    req.reg_addr    = addr;
    req.write_data  = d;
    req.port_a_pins = pa;
    req.port_b_pins = pb;
    {req.ca1_event, req.ca2_event, req.cb1_event, req.cb2_event} = ev;
    return req;
  endfunction

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        hold_cycles--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", got));
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("irq", 8'(got.irq), 8'(want.irq));
        check_field("port_a_out", got.port_a_out, want.port_a_out);
        check_field("port_a_dir", got.port_a_dir, want.port_a_dir);
        check_field("port_b_out", got.port_b_out, want.port_b_out);
        check_field("port_b_dir", got.port_b_dir, want.port_b_dir);
        check_field("ca2_level", 8'(got.ca2_level), 8'(want.ca2_level));
        check_field("cb2_level", 8'(got.cb2_level), 8'(want.cb2_level));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("versatile_interface_adapter_top verification failed");
      $finish;
    end
  end

  task automatic random_traffic(input int unsigned count);
    in_t         req;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      req.action = (pick < 36) ? ACT_READ : (pick < 70) ? ACT_WRITE :
                   (pick < 98) ? ACT_TICK : ACT_NONE;
      req.reg_addr    = 4'($urandom_range(15));
      req.write_data  = 8'($urandom_range(255));
      req.port_a_pins = 8'($urandom_range(255));
      req.port_b_pins = 8'($urandom_range(255));
      req.ca1_event   = 1'($urandom_range(1));
      req.ca2_event   = 1'($urandom_range(1));
      req.cb1_event   = 1'($urandom_range(1));
      req.cb2_event   = 1'($urandom_range(1));
      // short timer periods so that expiry is reached often
      if (action_e'(req.action) == ACT_WRITE && $urandom_range(9) < 8) begin
        case (reg_e'(req.reg_addr))
          REG_T1CL, REG_T1LL, REG_T2CL: req.write_data = 8'($urandom_range(24));
          REG_T1CH, REG_T1LH, REG_T2CH: req.write_data = ($urandom_range(9) == 0) ? 8'd1 : 8'd0;
          default: begin
          end
        endcase
      end
      send_word(req);
    end
  endtask

  task automatic test_directed();
    send_word(make_word(ACT_WRITE, REG_IER, 8'hFF, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_TICK, REG_ORB, 8'h00, 8'hFF, 8'hFF, 4'hF));
    send_word(make_word(ACT_READ, REG_IFR, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_DDRA, 8'hFF, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_ORA, 8'hAA, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_DDRB, 8'h0F, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_ORB, 8'h5A, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_READ, REG_ORB, 8'h00, 8'h00, 8'hFF, 4'h0));
    send_word(make_word(ACT_WRITE, REG_ORA_NH, 8'h55, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_READ, REG_ORA_NH, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_DDRA, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_READ, REG_ORA, 8'h00, 8'hC3, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_PCR, 8'hEE, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_PCR, 8'hCC, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_PCR, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_IFR, 8'h7F, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_NONE, REG_T1CH, 8'hFF, 8'hFF, 8'hFF, 4'hF));
    // free run with a zero latch, then a short free-running period with pb7 toggle
    send_word(make_word(ACT_WRITE, REG_ACR, 8'hC0, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T1CL, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T1CH, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T1CL, 8'h02, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T1CH, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_READ, REG_T1CL, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T2CL, 8'h01, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_WRITE, REG_T2CH, 8'h00, 8'h00, 8'h00, 4'h0));
    send_word(make_word(ACT_TICK, REG_ORB, 8'h00, 8'h00, 8'h00, 4'h0));
  endtask

  task automatic test_slow_sink();
    send_idle_pct = 22;
    recv_idle_pct = 61;
    random_traffic(650);
  endtask

  task automatic test_slow_source();
    send_idle_pct = 61;
    recv_idle_pct = 22;
    random_traffic(650);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(600);
  endtask

  task automatic test_input_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 300;
    random_traffic(60);
  endtask

  initial begin
    rst_ni       = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    reset_adapter_model();
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    test_slow_sink();
    test_slow_source();
    test_full_rate();
    test_input_stall();

    recv_idle_pct = 0;
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_count == 0) begin
      $display("versatile_interface_adapter_top verification clean");
    end else begin
      $display("versatile_interface_adapter_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/via_pkg.sv
sv/via_if.sv
sv/versatile_interface_adapter_top.sv
tb/sv/testbench.sv
